[src/tg_pkg.sv]
// Shared widths, constants and types of the triangle tangent pipeline.
package tg_pkg;
  localparam int EW  = 17;          // edge and UV delta width
  localparam int PW  = 2 * EW;      // product width
  localparam int NW  = PW + 1;      // numerator and determinant width
  localparam int SH  = 20;          // numerator pre-scale shift
  localparam int XW  = NW + SH;     // dividend width
  localparam int QW  = 32;          // quotient bits kept
  localparam int CW  = NW + QW;     // compare width in the divider
  localparam int LANES = 3;
  localparam int OVF_SH = QW - SH;  // |N|<<SH >= |D|<<QW  <=>  |N| >= |D|<<OVF_SH

  typedef struct packed {
    logic              valid;
    logic              mesh_end;
    logic              degen;
    logic [LANES-1:0]  neg;
    logic [LANES-1:0]  ovf;
  } side_t;

  typedef struct packed {
    side_t                       side;
    logic [NW-1:0]               dm;
    logic [LANES-1:0][XW-1:0]    rem;
    logic [LANES-1:0][QW-1:0]    q;
  } div_t;
endpackage

[src/triangle_tangent_generator_unit.sv]
// Top level of the per-triangle tangent pipeline.
//
// Usage: drive one triangle on the in_ ports and raise start; the transfer
// happens at a rising edge with start high and busy low. busy is always low,
// so a triangle can be sent in every cycle.
// Each triangle yields one result on the out_ ports, shown for exactly one
// cycle with out_valid high, after it passes through the stages listed below.
// Throughput is one triangle per cycle: 4 set-up stages (differences,
// 17x17 products, numerators/determinant, magnitudes and overflow check),
// 32 restoring divider stages (one quotient bit each), one output stage.
// Results leave in input order. The receiver cannot stall, so no
// backpressure exists anywhere in the pipeline.
// Synchronous reset (rst_n low) clears all valid bits; items in flight are
// dropped. Data registers are not reset.
module triangle_tangent_generator_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  logic [47:0]         in_vertex_a_pos,
  input  logic [47:0]         in_vertex_b_pos,
  input  logic [47:0]         in_vertex_c_pos,
  input  logic [31:0]         in_vertex_a_uv,
  input  logic [31:0]         in_vertex_b_uv,
  input  logic [31:0]         in_vertex_c_uv,
  input  logic                in_mesh_end_in,
  output logic                out_valid,
  output logic signed [31:0]  out_tangent_x,
  output logic signed [31:0]  out_tangent_y,
  output logic signed [31:0]  out_tangent_z,
  output logic                out_degenerate,
  output logic                out_saturated,
  output logic                out_mesh_end_out
);
  import tg_pkg::*;

  div_t chain [QW+1];

  assign busy = 1'b0;

  tg_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (start & ~busy),
    .pos_a    (in_vertex_a_pos),
    .pos_b    (in_vertex_b_pos),
    .pos_c    (in_vertex_c_pos),
    .uv_a     (in_vertex_a_uv),
    .uv_b     (in_vertex_b_uv),
    .uv_c     (in_vertex_c_uv),
    .mesh_end (in_mesh_end_in),
    .div_out  (chain[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_div
    tg_div_stage #(.BIT(QW - 1 - i)) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .d_in  (chain[i]),
      .d_out (chain[i+1])
    );
  end

  tg_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .d_in             (chain[QW]),
    .out_valid        (out_valid),
    .out_tangent_x    (out_tangent_x),
    .out_tangent_y    (out_tangent_y),
    .out_tangent_z    (out_tangent_z),
    .out_degenerate   (out_degenerate),
    .out_saturated    (out_saturated),
    .out_mesh_end_out (out_mesh_end_out)
  );
endmodule

[src/tg_front.sv]
// Edge, delta, product and determinant stages, then divider set-up.
module tg_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic [47:0]         pos_a,
  input  logic [47:0]         pos_b,
  input  logic [47:0]         pos_c,
  input  logic [31:0]         uv_a,
  input  logic [31:0]         uv_b,
  input  logic [31:0]         uv_c,
  input  logic                mesh_end,
  output tg_pkg::div_t        div_out
);
  import tg_pkg::*;

  // stage 1: differences
  logic                                 v1_r;
  logic                                 m1_r;
  logic signed [LANES-1:0][EW-1:0]      e1_r, e2_r;
  logic signed [EW-1:0]                 d1u_r, d1v_r, d2u_r, d2v_r;
  // stage 2: products
  logic                                 v2_r;
  logic                                 m2_r;
  logic signed [LANES-1:0][PW-1:0]      p1_r, p2_r;
  logic signed [PW-1:0]                 pd1_r, pd2_r;
  // stage 3: numerators and determinant
  logic                                 v3_r;
  logic                                 m3_r;
  logic signed [LANES-1:0][NW-1:0]      num_r;
  logic signed [NW-1:0]                 det_r;
  // stage 4: magnitudes
  div_t                                 div_r, div_nxt;

  function automatic logic signed [EW-1:0] sub16(input logic [15:0] x, input logic [15:0] y);
    sub16 = $signed({x[15], x}) - $signed({y[15], y});
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      div_r.side.valid <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      div_r.side.valid <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    m1_r <= mesh_end;
    for (int k = 0; k < LANES; k++) begin
      e1_r[k] <= sub16(pos_c[16*k +: 16], pos_a[16*k +: 16]);
      e2_r[k] <= sub16(pos_b[16*k +: 16], pos_a[16*k +: 16]);
    end
    d1u_r <= sub16(uv_c[15:0],  uv_a[15:0]);
    d1v_r <= sub16(uv_c[31:16], uv_a[31:16]);
    d2u_r <= sub16(uv_b[15:0],  uv_a[15:0]);
    d2v_r <= sub16(uv_b[31:16], uv_a[31:16]);

    m2_r <= m1_r;
    for (int k = 0; k < LANES; k++) begin
      p1_r[k] <= $signed(e1_r[k]) * $signed(d2v_r);
      p2_r[k] <= $signed(e2_r[k]) * $signed(d1v_r);
    end
    pd1_r <= $signed(d1u_r) * $signed(d2v_r);
    pd2_r <= $signed(d1v_r) * $signed(d2u_r);

    m3_r <= m2_r;
    for (int k = 0; k < LANES; k++) begin
      num_r[k] <= $signed({p1_r[k][PW-1], p1_r[k]}) - $signed({p2_r[k][PW-1], p2_r[k]});
    end
    det_r <= $signed({pd1_r[PW-1], pd1_r}) - $signed({pd2_r[PW-1], pd2_r});

    div_r.side.mesh_end <= div_nxt.side.mesh_end;
    div_r.side.degen    <= div_nxt.side.degen;
    div_r.side.neg      <= div_nxt.side.neg;
    div_r.side.ovf      <= div_nxt.side.ovf;
    div_r.dm            <= div_nxt.dm;
    div_r.rem           <= div_nxt.rem;
    div_r.q             <= div_nxt.q;
  end

  always_comb begin
    logic [NW-1:0] nm;
    div_nxt            = div_r;
    div_nxt.side.valid = v3_r;
    div_nxt.side.mesh_end = m3_r;
    div_nxt.side.degen = (det_r == '0);
    div_nxt.dm         = det_r[NW-1] ? NW'(-det_r) : NW'(det_r);
    for (int k = 0; k < LANES; k++) begin
      nm = num_r[k][NW-1] ? NW'(-num_r[k]) : NW'(num_r[k]);
      div_nxt.side.neg[k] = num_r[k][NW-1] ^ det_r[NW-1];
      div_nxt.side.ovf[k] = ({{OVF_SH{1'b0}}, nm} >= {div_nxt.dm, {OVF_SH{1'b0}}});
      div_nxt.rem[k] = {nm, {SH{1'b0}}};
      div_nxt.q[k]   = '0;
    end
  end

  assign div_out = div_r;
endmodule

[src/tg_div_stage.sv]
// One restoring division step for all three lanes, producing quotient bit BIT.
module tg_div_stage #(
  parameter int BIT = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  tg_pkg::div_t  d_in,
  output tg_pkg::div_t  d_out
);
  import tg_pkg::*;

  div_t st_r, st_nxt;

  always_comb begin
    logic [CW-1:0] shd;
    logic [CW-1:0] rx;
    st_nxt = d_in;
    shd = CW'(d_in.dm) << BIT;
    for (int k = 0; k < LANES; k++) begin
      rx = CW'(d_in.rem[k]);
      if (rx >= shd) begin
        st_nxt.rem[k]  = d_in.rem[k] - shd[XW-1:0];
        st_nxt.q[k][BIT] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.side.valid <= 1'b0;
    end else begin
      st_r.side.valid <= st_nxt.side.valid;
    end
  end

  always_ff @(posedge clk) begin
    st_r.side.mesh_end <= st_nxt.side.mesh_end;
    st_r.side.degen    <= st_nxt.side.degen;
    st_r.side.neg      <= st_nxt.side.neg;
    st_r.side.ovf      <= st_nxt.side.ovf;
    st_r.dm            <= st_nxt.dm;
    st_r.rem           <= st_nxt.rem;
    st_r.q             <= st_nxt.q;
  end

  assign d_out = st_r;
endmodule

[src/tg_back.sv]
// Sign restore, clamp to Q12.20, degenerate forcing and output register.
module tg_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tg_pkg::div_t        d_in,
  output logic                out_valid,
  output logic signed [31:0]  out_tangent_x,
  output logic signed [31:0]  out_tangent_y,
  output logic signed [31:0]  out_tangent_z,
  output logic                out_degenerate,
  output logic                out_saturated,
  output logic                out_mesh_end_out
);
  import tg_pkg::*;

  localparam logic [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};

  logic                         valid_r;
  logic [LANES-1:0][QW-1:0]     t_r, t_nxt;
  logic                         degen_r, sat_r, sat_nxt, mend_r;

  always_comb begin
    sat_nxt = 1'b0;
    for (int k = 0; k < LANES; k++) begin
      if (d_in.side.degen) begin
        t_nxt[k] = '0;
      end else if (d_in.side.ovf[k]) begin
        t_nxt[k] = d_in.side.neg[k] ? QMIN : QMAX;
        sat_nxt  = 1'b1;
      end else if (d_in.side.neg[k]) begin
        if (d_in.q[k] > QMIN) begin
          t_nxt[k] = QMIN;
          sat_nxt  = 1'b1;
        end else begin
          t_nxt[k] = -d_in.q[k];
        end
      end else if (d_in.q[k][QW-1]) begin
        t_nxt[k] = QMAX;
        sat_nxt  = 1'b1;
      end else begin
        t_nxt[k] = d_in.q[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= d_in.side.valid;
    end
  end

  always_ff @(posedge clk) begin
    t_r     <= t_nxt;
    degen_r <= d_in.side.degen;
    sat_r   <= sat_nxt;
    mend_r  <= d_in.side.mesh_end;
  end

  assign out_valid        = valid_r;
  assign out_tangent_x    = $signed(t_r[0]);
  assign out_tangent_y    = $signed(t_r[1]);
  assign out_tangent_z    = $signed(t_r[2]);
  assign out_degenerate   = degen_r;
  assign out_saturated    = sat_r;
  assign out_mesh_end_out = mend_r;
endmodule

[src/tg_checker.sv]
// Port-level checks of the tangent pipeline, bound to the top level.
module tg_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input logic signed [31:0] out_tangent_x,
  input logic signed [31:0] out_tangent_y,
  input logic signed [31:0] out_tangent_z,
  input logic               out_degenerate,
  input logic               out_saturated
);
  localparam int LAT = 37;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe after reset");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LAT out_valid)
    else $error("transfer did not produce a result");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without a matching transfer");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_degenerate) |->
      (out_tangent_x == 0 && out_tangent_y == 0 && out_tangent_z == 0 && !out_saturated))
    else $error("degenerate result not zero");
endmodule

bind triangle_tangent_generator_unit tg_checker u_tg_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_valid     (out_valid),
  .out_tangent_x (out_tangent_x),
  .out_tangent_y (out_tangent_y),
  .out_tangent_z (out_tangent_z),
  .out_degenerate(out_degenerate),
  .out_saturated (out_saturated)
);
